// ----- hdl/coulomb_gauge_vector_potential_assert.svh -----
// Assertion macros for the Coulomb-gauge vector potential block.
// Included by the RTL files that carry concurrent assertions; needs nothing else.
`ifndef COULOMB_GAUGE_VECTOR_POTENTIAL_ASSERT_SVH
`define COULOMB_GAUGE_VECTOR_POTENTIAL_ASSERT_SVH
`ifndef ASSERT_OFF
`define CGVP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cgvp assertion failed");
`define CGVP_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cgvp assertion failed");
`else
`define CGVP_ASSERT(name, clk, rst_n, prop)
`define CGVP_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

// ----- hdl/cgvp_pkg.sv -----
// Package for the Coulomb-gauge vector potential block.
// Holds register indexes, the divider lane type and the divider step function.
`default_nettype none
package cgvp_pkg;

  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = 16;
  localparam int unsigned REM_W      = 44;

  typedef enum logic [1:0] {
    REG_GRID_NY      = 2'd0,
    REG_GRID_NZ      = 2'd1,
    REG_LENGTH_SCALE = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [31:0]      w;
    logic             neg;
    logic             ovf;
  } lane_t;

  // Restoring division: dividend bits leave the top of w, quotient bits enter below.
  function automatic lane_t div_steps(lane_t l, logic [REM_W-1:0] d);
    lane_t          o;
    logic [REM_W:0] r;
    logic [REM_W:0] t;
    logic           qb;
    o = l;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r = {o.rem, o.w[31]};
      t = r - {1'b0, d};
      qb = (r >= {1'b0, d});
      o.rem = qb ? t[REM_W-1:0] : r[REM_W-1:0];
      o.w = {o.w[30:0], qb};
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/coulomb_gauge_vector_potential.sv -----
// Coulomb-gauge vector potential A = i (n x B) scale / |n|^2 of one Fourier mode.
// One word is accepted per cycle.
// The datapath is a 24-stage pipeline whose 32-bit divider runs two steps per stage.
// busy_o stays low; the receiver cannot stall, so nothing ever backs up.
// Reset clears the valid bits and loads the grid sizes with MAX_GRID and scale with 1.0.
// Uses cgvp_pkg and coulomb_gauge_vector_potential_assert.svh.
`default_nettype none
`include "coulomb_gauge_vector_potential_assert.svh"
module coulomb_gauge_vector_potential #(
  parameter int unsigned MAX_GRID = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [11:0]        kx_index_i,
  input  wire logic [11:0]        ky_index_i,
  input  wire logic [11:0]        kz_index_i,
  input  wire logic signed [31:0] bx_re_i,
  input  wire logic signed [31:0] bx_im_i,
  input  wire logic signed [31:0] by_re_i,
  input  wire logic signed [31:0] by_im_i,
  input  wire logic signed [31:0] bz_re_i,
  input  wire logic signed [31:0] bz_im_i,
  output logic                    done_o,
  output logic signed [31:0]      ax_re_o,
  output logic signed [31:0]      ax_im_o,
  output logic signed [31:0]      ay_re_o,
  output logic signed [31:0]      ay_im_o,
  output logic signed [31:0]      az_re_o,
  output logic signed [31:0]      az_im_o,
  output logic                    zero_mode_o,
  output logic                    saturated_o
);

  localparam int unsigned NS = cgvp_pkg::DIV_STAGES;
  localparam int unsigned RW = cgvp_pkg::REM_W;

  logic [12:0] grid_ny_q, grid_nz_q;
  logic [31:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_ny_q <= 13'(MAX_GRID);
      grid_nz_q <= 13'(MAX_GRID);
      scale_q   <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cgvp_pkg::REG_GRID_NY:      grid_ny_q <= cfg_wdata_i[12:0];
        cgvp_pkg::REG_GRID_NZ:      grid_nz_q <= cfg_wdata_i[12:0];
        cgvp_pkg::REG_LENGTH_SCALE: scale_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  function automatic logic signed [13:0] fold(logic [11:0] idx, logic [12:0] n);
    logic [13:0] diff;
    diff = {2'b00, idx} - {1'b0, n};
    if ({1'b0, idx} <= (n >> 1)) return $signed({2'b00, idx});
    return $signed(diff);
  endfunction

  // Stage 1: wavenumbers (ky and kz folded, kx as given) and B.
  logic                v1_q;
  logic signed [13:0]  k1_q [3];
  logic signed [31:0]  b1_q [6];

  // Stage 2: cross-product terms as pairs of products, squares.
  logic                v2_q, z2_q;
  logic signed [45:0]  pa2_q [6];
  logic signed [45:0]  pb2_q [6];
  logic [26:0]         sq2_q [3];

  // Stage 3: signed numerators and |n|^2.
  logic                v3_q, z3_q;
  logic signed [46:0]  t3_q [6];
  logic [27:0]         n2_3_q;

  // Stage 4: sign and magnitude, divisor.
  logic                v4_q, z4_q;
  logic                neg4_q [6];
  logic [46:0]         mag4_q [6];
  logic [RW-1:0]       d4_q;

  // Stage 5: partial products with the scale.
  logic                v5_q, z5_q;
  logic                neg5_q [6];
  logic [63:0]         plo5_q [6];
  logic [46:0]         phi5_q [6];
  logic [RW-1:0]       d5_q;

  // Stage 6: full dividend.
  logic                v6_q, z6_q;
  logic                neg6_q [6];
  logic [78:0]         p6_q [6];
  logic [RW-1:0]       d6_q;

  // Divider stages.
  logic                dv_q [NS+1];
  logic                dz_q [NS+1];
  logic [RW-1:0]       dd_q [NS+1];
  cgvp_pkg::lane_t     dl_q [NS+1][6];

  logic signed [13:0]  ka [6], kb [6];
  logic signed [31:0]  ba [6], bb [6];

  localparam int BXR = 0, BXI = 1, BYR = 2, BYI = 3, BZR = 4, BZI = 5;
  localparam int KX = 0, KY = 1, KZ = 2;

  always_comb begin
    ka[0] = k1_q[KZ]; ba[0] = b1_q[BYI]; kb[0] = k1_q[KY]; bb[0] = b1_q[BZI];
    ka[1] = k1_q[KY]; ba[1] = b1_q[BZR]; kb[1] = k1_q[KZ]; bb[1] = b1_q[BYR];
    ka[2] = k1_q[KX]; ba[2] = b1_q[BZI]; kb[2] = k1_q[KZ]; bb[2] = b1_q[BXI];
    ka[3] = k1_q[KZ]; ba[3] = b1_q[BXR]; kb[3] = k1_q[KX]; bb[3] = b1_q[BZR];
    ka[4] = k1_q[KY]; ba[4] = b1_q[BXI]; kb[4] = k1_q[KX]; bb[4] = b1_q[BYI];
    ka[5] = k1_q[KX]; ba[5] = b1_q[BYR]; kb[5] = k1_q[KY]; bb[5] = b1_q[BXR];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      for (int s = 0; s <= NS; s++) dv_q[s] <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      dv_q[0] <= v6_q;
      for (int s = 0; s < NS; s++) dv_q[s+1] <= dv_q[s];
    end
  end

  logic signed [27:0] sq_full [3];
  always_comb begin
    for (int j = 0; j < 3; j++) sq_full[j] = 28'(k1_q[j]) * 28'(k1_q[j]);
  end

  always_ff @(posedge clk_i) begin
    k1_q[KX] <= $signed({2'b00, kx_index_i});
    k1_q[KY] <= fold(ky_index_i, grid_ny_q);
    k1_q[KZ] <= fold(kz_index_i, grid_nz_q);
    b1_q[BXR] <= bx_re_i;
    b1_q[BXI] <= bx_im_i;
    b1_q[BYR] <= by_re_i;
    b1_q[BYI] <= by_im_i;
    b1_q[BZR] <= bz_re_i;
    b1_q[BZI] <= bz_im_i;

    z2_q <= (k1_q[KX] == 14'sd0) && (k1_q[KY] == 14'sd0) && (k1_q[KZ] == 14'sd0);
    for (int j = 0; j < 6; j++) begin
      pa2_q[j] <= 46'(ka[j]) * 46'(ba[j]);
      pb2_q[j] <= 46'(kb[j]) * 46'(bb[j]);
    end
    for (int j = 0; j < 3; j++) sq2_q[j] <= sq_full[j][26:0];

    z3_q <= z2_q;
    for (int j = 0; j < 6; j++) t3_q[j] <= 47'(pa2_q[j]) - 47'(pb2_q[j]);
    n2_3_q <= 28'(sq2_q[0]) + 28'(sq2_q[1]) + 28'(sq2_q[2]);

    z4_q <= z3_q;
    d4_q <= {n2_3_q, 16'h0000};
    for (int j = 0; j < 6; j++) begin
      neg4_q[j] <= t3_q[j][46];
      mag4_q[j] <= t3_q[j][46] ? 47'(-t3_q[j]) : 47'(t3_q[j]);
    end

    z5_q <= z4_q;
    d5_q <= d4_q;
    for (int j = 0; j < 6; j++) begin
      neg5_q[j] <= neg4_q[j];
      plo5_q[j] <= 64'(mag4_q[j][31:0]) * 64'(scale_q);
      phi5_q[j] <= 47'(mag4_q[j][46:32]) * 47'(scale_q);
    end

    z6_q <= z5_q;
    d6_q <= d5_q;
    for (int j = 0; j < 6; j++) begin
      neg6_q[j] <= neg5_q[j];
      p6_q[j] <= 79'(plo5_q[j]) + (79'(phi5_q[j]) << 32);
    end

    dz_q[0] <= z6_q;
    dd_q[0] <= d6_q;
    for (int j = 0; j < 6; j++) begin
      dl_q[0][j].rem <= p6_q[j][RW+31:32];
      dl_q[0][j].w   <= p6_q[j][31:0];
      dl_q[0][j].neg <= neg6_q[j];
      dl_q[0][j].ovf <= p6_q[j][78:32] >= 47'(d6_q);
    end

    for (int s = 0; s < NS; s++) begin
      dz_q[s+1] <= dz_q[s];
      dd_q[s+1] <= dd_q[s];
      for (int j = 0; j < 6; j++) dl_q[s+1][j] <= cgvp_pkg::div_steps(dl_q[s][j], dd_q[s]);
    end
  end

  logic        lsat [6];
  logic [31:0] lval [6];
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      lsat[j] = dl_q[NS][j].ovf ||
                (dl_q[NS][j].neg ? (dl_q[NS][j].w > 32'h8000_0000)
                                 : (dl_q[NS][j].w > 32'h7FFF_FFFF));
      if (lsat[j]) lval[j] = dl_q[NS][j].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else lval[j] = dl_q[NS][j].neg ? (32'd0 - dl_q[NS][j].w) : dl_q[NS][j].w;
    end
  end

  logic        done_q, zero_q, sat_q;
  logic [31:0] a_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= dv_q[NS];
  end

  always_ff @(posedge clk_i) begin
    zero_q <= dz_q[NS];
    sat_q  <= !dz_q[NS] && (lsat[0] || lsat[1] || lsat[2] || lsat[3] || lsat[4] || lsat[5]);
    for (int j = 0; j < 6; j++) a_q[j] <= dz_q[NS] ? 32'd0 : lval[j];
  end

  assign done_o      = done_q;
  assign zero_mode_o = zero_q;
  assign saturated_o = sat_q;
  assign ax_re_o     = $signed(a_q[0]);
  assign ax_im_o     = $signed(a_q[1]);
  assign ay_re_o     = $signed(a_q[2]);
  assign ay_im_o     = $signed(a_q[3]);
  assign az_re_o     = $signed(a_q[4]);
  assign az_im_o     = $signed(a_q[5]);

  `CGVP_ASSERT(a_zero_no_sat, clk_i, rst_ni, done_o |-> !(zero_mode_o && saturated_o))
  `CGVP_ASSERT(a_zero_clear, clk_i, rst_ni, (done_o && zero_mode_o) |-> ((ax_re_o == 32'sd0) && (ay_im_o == 32'sd0) && (az_re_o == 32'sd0)))
  `CGVP_ASSERT(a_rem_bound, clk_i, rst_ni, (dv_q[0] && !dz_q[0] && !dl_q[0][0].ovf) |-> (dl_q[0][0].rem < dd_q[0]))
  `CGVP_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, accept, v1_q)

endmodule
`default_nettype wire
